[rtl/gdda_pkg.sv]
// shared constants, field offsets and types for the grid ray dda traversal block
// no dependencies; imported by grid_ray_dda_traversal and gdda_arith
`default_nettype none

package gdda_pkg;

	localparam int MAP_DIM   = 64;
	localparam int MAX_STEPS = 128;

	localparam int MAP_DEPTH = MAP_DIM * MAP_DIM;
	localparam int MAP_AW    = $clog2(MAP_DEPTH);
	localparam int CNT_W     = $clog2(MAX_STEPS + 1);
	localparam int COORD_RAW = $clog2(MAP_DIM + MAX_STEPS) + 1;
	localparam int COORD_W   = (COORD_RAW > 10) ? COORD_RAW : 10;

	localparam int SIDE_W  = 40;
	localparam int DELTA_W = 32;
	localparam int DIST_W  = 17;
	localparam int PROD_W  = DIST_W + DELTA_W;
	localparam int FRAC_W  = 16;
	localparam int ORG_W   = 22;
	localparam int CELL_W  = 6;
	localparam int OUT_C_W = 9;

	localparam logic [SIDE_W-1:0]  SIDE_MAX  = '1;
	localparam logic [DELTA_W-1:0] DELTA_INF = '1;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 1'd1;
	localparam logic [CFG_DATA_W-1:0] MAP_SIZE_RST  = 7'd64;

	// request kinds on tuser
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_RAY   = 1'b1;

	// input tdata layout
	localparam int S_TDATA_W = 128;
	localparam int OFS_COL   = 0;
	localparam int OFS_ROW   = 6;
	localparam int OFS_WALL  = 12;
	localparam int OFS_OX    = 13;
	localparam int OFS_OY    = 35;
	localparam int OFS_NX    = 57;
	localparam int OFS_NY    = 58;
	localparam int OFS_DX    = 59;
	localparam int OFS_DY    = 91;
	localparam int S_USED_W  = 123;

	// output tdata layout
	localparam int M_TDATA_W = 104;
	localparam int M_USED_W  = 100;

	typedef struct packed {
		logic mul_en;
		logic mul_sel_y;
		logic load_x;
		logic load_y;
		logic step;
	} gdda_cmd_t;

endpackage

`default_nettype wire

[rtl/grid_ray_dda_traversal.sv]
// ray request: the result is valid once the traversal ends, after n steps (1 to MAX_STEPS);
// idle again as the result loads, so the next request is taken after that, plus any wait
// on m_tready for the previous result; each step is a step state and a check state, set by
// the registered wall map read. cell write: taken while idle. one request in flight at a time.
// reset: map_width and map_height go to 64, then a clearing pass over every cell
// zeroes the wall map; no request is taken during the pass, configuration writes are.
// top level of the grid ray traversal; depends on gdda_pkg, gdda_ram and gdda_arith
`default_nettype none

module grid_ray_dda_traversal (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [gdda_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gdda_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// cell_col, cell_row, cell_is_wall, origin_x, origin_y, dir_x_negative,
	// dir_y_negative, delta_x, delta_y, zero fill
	input  logic [gdda_pkg::S_TDATA_W-1:0]    s_tdata,
	// kind
	input  logic [0:0]                        s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// hit_col, hit_row, side_crossed, hit_found, final_side_x, final_side_y, zero fill
	output logic [gdda_pkg::M_TDATA_W-1:0]    m_tdata
);
	import gdda_pkg::*;

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_MUL_X  = 3'd2;
	localparam logic [2:0] ST_MUL_Y  = 3'd3;
	localparam logic [2:0] ST_LOAD_Y = 3'd4;
	localparam logic [2:0] ST_STEP   = 3'd5;
	localparam logic [2:0] ST_CHECK  = 3'd6;
	localparam logic [2:0] ST_DONE   = 3'd7;

	localparam logic signed [COORD_W-1:0] DIM_S    = COORD_W'(MAP_DIM);
	localparam logic signed [COORD_W-1:0] COORD_LO = COORD_W'(-256);
	localparam logic signed [COORD_W-1:0] COORD_HI = COORD_W'(255);
	localparam logic signed [COORD_W-1:0] ONE_S    = COORD_W'(1);
	localparam logic [MAP_AW-1:0]         CLR_LAST = MAP_AW'(MAP_DEPTH - 1);

	logic [2:0]            state_q;
	logic [MAP_AW-1:0]     clr_q;
	logic [CFG_DATA_W-1:0] map_width_q;
	logic [CFG_DATA_W-1:0] map_height_q;

	logic                  s_req;
	logic [CELL_W-1:0]     in_col;
	logic [CELL_W-1:0]     in_row;
	logic                  in_wall;
	logic [ORG_W-1:0]      in_ox;
	logic [ORG_W-1:0]      in_oy;
	logic                  in_nx;
	logic                  in_ny;
	logic [DELTA_W-1:0]    in_dx;
	logic [DELTA_W-1:0]    in_dy;
	logic                  wr_in_range;

	logic [DIST_W-1:0]     dist_x_q;
	logic [DIST_W-1:0]     dist_y_q;
	logic [DELTA_W-1:0]    dx_q;
	logic [DELTA_W-1:0]    dy_q;
	logic                  nx_q;
	logic                  ny_q;
	logic signed [COORD_W-1:0] col_q;
	logic signed [COORD_W-1:0] row_q;
	logic signed [COORD_W-1:0] col_nx;
	logic signed [COORD_W-1:0] row_nx;
	logic                  side_q;
	logic                  inb;
	logic                  inb_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  hit;
	logic                  fin;

	gdda_cmd_t             cmd;
	logic [SIDE_W-1:0]     side_x;
	logic [SIDE_W-1:0]     side_y;
	logic                  step_y;

	logic                  ram_we;
	logic [MAP_AW-1:0]     ram_waddr;
	logic                  ram_wdata;
	logic [MAP_AW-1:0]     ram_raddr;
	logic                  ram_rdata;

	logic                  out_load;
	logic                  m_tvalid_q;
	logic [M_USED_W-1:0]   m_data_q;
	logic [OUT_C_W-1:0]    out_col;
	logic [OUT_C_W-1:0]    out_row;

	assign s_tready = (state_q == ST_IDLE);
	assign s_req    = s_tvalid && s_tready;

	assign in_col  = s_tdata[OFS_COL +: CELL_W];
	assign in_row  = s_tdata[OFS_ROW +: CELL_W];
	assign in_wall = s_tdata[OFS_WALL];
	assign in_ox   = s_tdata[OFS_OX +: ORG_W];
	assign in_oy   = s_tdata[OFS_OY +: ORG_W];
	assign in_nx   = s_tdata[OFS_NX];
	assign in_ny   = s_tdata[OFS_NY];
	assign in_dx   = s_tdata[OFS_DX +: DELTA_W];
	assign in_dy   = s_tdata[OFS_DY +: DELTA_W];

	assign wr_in_range = (int'(in_col) < MAP_DIM) && (int'(in_row) < MAP_DIM);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q  <= MAP_SIZE_RST;
			map_height_q <= MAP_SIZE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAP_WIDTH:  map_width_q  <= cfg_data;
				REG_MAP_HEIGHT: map_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// next cell and wall bounds
	assign col_nx = step_y ? col_q : (nx_q ? col_q - ONE_S : col_q + ONE_S);
	assign row_nx = step_y ? (ny_q ? row_q - ONE_S : row_q + ONE_S) : row_q;
	assign inb = !col_nx[COORD_W-1] && !row_nx[COORD_W-1]
		&& (col_nx < $signed(COORD_W'(map_width_q)))
		&& (row_nx < $signed(COORD_W'(map_height_q)))
		&& (col_nx < DIM_S) && (row_nx < DIM_S);

	assign hit = inb_q && ram_rdata;
	assign fin = hit || (cnt_q == CNT_W'(MAX_STEPS));

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_MUL_X:  cmd.mul_en = 1'b1;
			ST_MUL_Y: begin
				cmd.mul_en    = 1'b1;
				cmd.mul_sel_y = 1'b1;
				cmd.load_x    = 1'b1;
			end
			ST_LOAD_Y: cmd.load_y = 1'b1;
			ST_STEP:   cmd.step   = 1'b1;
			default: ;
		endcase
	end

	always_comb begin
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = 1'b0;
		end else begin
			ram_we    = s_req && (s_tuser[0] == KIND_WRITE) && wr_in_range;
			ram_waddr = MAP_AW'(int'(in_row) * MAP_DIM + int'(in_col));
			ram_wdata = in_wall;
		end
		ram_raddr = inb ? MAP_AW'(int'(row_nx) * MAP_DIM + int'(col_nx)) : '0;
	end

	gdda_ram #(
		.WIDTH(1),
		.DEPTH(MAP_DEPTH)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	gdda_arith u_arith (
		.clk     (clk),
		.cmd     (cmd),
		.dist_x  (dist_x_q),
		.dist_y  (dist_y_q),
		.delta_x (dx_q),
		.delta_y (dy_q),
		.side_x  (side_x),
		.side_y  (side_y),
		.step_y  (step_y)
	);

	assign out_load = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + MAP_AW'(1);
					if (clr_q == CLR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_req && s_tuser[0] == KIND_RAY) begin
						state_q <= ST_MUL_X;
					end
				end
				ST_MUL_X:  state_q <= ST_MUL_Y;
				ST_MUL_Y:  state_q <= ST_LOAD_Y;
				ST_LOAD_Y: state_q <= ST_STEP;
				ST_STEP:   state_q <= ST_CHECK;
				ST_CHECK:  state_q <= fin ? ST_DONE : ST_STEP;
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ray registers
	always_ff @(posedge clk) begin
		if (s_req) begin
			dist_x_q <= in_nx ? DIST_W'(in_ox[FRAC_W-1:0])
				: DIST_W'(65536) - DIST_W'(in_ox[FRAC_W-1:0]);
			dist_y_q <= in_ny ? DIST_W'(in_oy[FRAC_W-1:0])
				: DIST_W'(65536) - DIST_W'(in_oy[FRAC_W-1:0]);
			dx_q     <= in_dx;
			dy_q     <= in_dy;
			nx_q     <= in_nx;
			ny_q     <= in_ny;
			col_q    <= COORD_W'(in_ox[ORG_W-1:FRAC_W]);
			row_q    <= COORD_W'(in_oy[ORG_W-1:FRAC_W]);
		end else if (state_q == ST_STEP) begin
			col_q  <= col_nx;
			row_q  <= row_nx;
			side_q <= step_y;
			inb_q  <= inb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (s_req) begin
			cnt_q <= '0;
		end else if (state_q == ST_STEP) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// result register
	assign out_col = (col_q < COORD_LO) ? COORD_LO[OUT_C_W-1:0]
		: (col_q > COORD_HI) ? COORD_HI[OUT_C_W-1:0] : col_q[OUT_C_W-1:0];
	assign out_row = (row_q < COORD_LO) ? COORD_LO[OUT_C_W-1:0]
		: (row_q > COORD_HI) ? COORD_HI[OUT_C_W-1:0] : row_q[OUT_C_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// hit flag is captured here from the last check
	logic hit_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_CHECK) begin
			hit_q <= hit;
		end
		if (out_load) begin
			m_data_q <= {side_y, side_x, hit_q, side_q, out_row, out_col};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(M_TDATA_W - M_USED_W)'(0), m_data_q};

`ifndef SYNTHESIS
	a_step_limit: assert property (@(posedge clk) disable iff (!arst_n)
		int'(cnt_q) <= MAX_STEPS)
		else $error("step count past limit");

	a_ray_start: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser[0] == KIND_RAY) |=> (state_q == ST_MUL_X))
		else $error("ray request did not start the multiply");

	a_check_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK) |-> ($past(state_q) == ST_STEP))
		else $error("check without a preceding step");

	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE && state_q != ST_CLEAR) |-> !ram_we)
		else $error("map write during traversal");
`endif

endmodule

`default_nettype wire

[rtl/gdda_ram.sv]
// generic single write port, single read port ram with registered read data
// no dependencies
`default_nettype none

module gdda_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[rtl/gdda_arith.sv]
// shared arithmetic unit: one multiplier for the start side distances and one
// saturating add and compare for every traversal step; depends on gdda_pkg
`default_nettype none

module gdda_arith (
	input  logic                          clk,
	input  gdda_pkg::gdda_cmd_t           cmd,
	input  logic [gdda_pkg::DIST_W-1:0]   dist_x,
	input  logic [gdda_pkg::DIST_W-1:0]   dist_y,
	input  logic [gdda_pkg::DELTA_W-1:0]  delta_x,
	input  logic [gdda_pkg::DELTA_W-1:0]  delta_y,
	output logic [gdda_pkg::SIDE_W-1:0]   side_x,
	output logic [gdda_pkg::SIDE_W-1:0]   side_y,
	output logic                          step_y
);
	import gdda_pkg::*;

	logic [PROD_W-1:0]  prod_s1;
	logic [DIST_W-1:0]  mul_a;
	logic [DELTA_W-1:0] mul_b;
	logic [SIDE_W-1:0]  start_val;
	logic [SIDE_W-1:0]  side_x_q;
	logic [SIDE_W-1:0]  side_y_q;
	logic [SIDE_W-1:0]  add_side;
	logic [DELTA_W-1:0] add_delta;
	logic [SIDE_W:0]    add_sum;
	logic [SIDE_W-1:0]  add_res;

	assign mul_a = cmd.mul_sel_y ? dist_y : dist_x;
	assign mul_b = cmd.mul_sel_y ? delta_y : delta_x;

	assign start_val = SIDE_W'(prod_s1[PROD_W-1:FRAC_W]);

	// tie steps along y
	assign step_y    = !(side_x_q < side_y_q);
	assign add_side  = step_y ? side_y_q : side_x_q;
	assign add_delta = step_y ? delta_y : delta_x;
	assign add_sum   = {1'b0, add_side} + (SIDE_W + 1)'(add_delta);
	assign add_res   = (add_delta == DELTA_INF || add_sum[SIDE_W]) ? SIDE_MAX
		: add_sum[SIDE_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_s1 <= PROD_W'(mul_a) * PROD_W'(mul_b);
		end
		if (cmd.load_x) begin
			side_x_q <= (delta_x == DELTA_INF) ? SIDE_MAX : start_val;
		end else if (cmd.step && !step_y) begin
			side_x_q <= add_res;
		end
		if (cmd.load_y) begin
			side_y_q <= (delta_y == DELTA_INF) ? SIDE_MAX : start_val;
		end else if (cmd.step && step_y) begin
			side_y_q <= add_res;
		end
	end

	assign side_x = side_x_q;
	assign side_y = side_y_q;

endmodule

`default_nettype wire
